// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dis_pkg.sv =====
// ----------------------------------------------------------------------------
// dis_pkg
// Types and character constants for the decimal integer stream parser.
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DIGIT_W = 4;
    // magnitude * 10 + 9 fits in VALUE_W + 4 bits
    localparam int unsigned WIDE_W  = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [WIDE_W-1:0] MAG_LIMIT = 36'h0_7FFF_FFFF;

    typedef enum logic [3:0] {
        PH_BEFORE_SIGN   = 4'b0001,
        PH_BEFORE_DIGITS = 4'b0010,
        PH_DIGITS        = 4'b0100,
        PH_AFTER_DIGITS  = 4'b1000
    } phase_t;

endpackage

// ===== src/decimal_integer_stream_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_integer_stream_parser
// Streaming ASCII to signed 32-bit decimal integer parser.
// ----------------------------------------------------------------------------
// One ASCII byte per request goes in, one result per request comes out. The
// parser walks through four phases: leading whitespace (codes 9..13 and 32),
// an optional '+' or '-', decimal digits, then trailing whitespace only. A
// byte that does not fit the syntax at its point is reported with accepted=0
// and leaves the parser state untouched. restart=1 clears the state before
// the byte is taken. value is the signed number so far (0 until a digit is
// seen, value_valid marks it usable) and wraps modulo 2^32; overflow is
// sticky once the exact magnitude has passed 2147483647. Throughput is one
// byte per clock unless stalled: the whole update, a multiply by ten done
// as two shifts and an add, plus the phase step, sits between the state
// registers and the result register. The result register lets a new byte
// in while the previous result still waits; in_stall is raised only when
// that register is full and the output side stalls.
module decimal_integer_stream_parser
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dis_pkg::CHAR_W-1:0]     ch,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic                           value_valid,
    output logic signed [dis_pkg::VALUE_W-1:0] value,
    output logic                           overflow
);
    import dis_pkg::*;
    `include "assert_macros.svh"

    // parser state
    phase_t               phase_reg, phase_next;
    logic [VALUE_W-1:0]   mag_reg,   mag_next;
    logic                 neg_reg,   neg_next;
    logic                 ovf_reg,   ovf_next;

    // result register
    logic                 out_valid_reg;
    logic                 accepted_reg,    accepted_next;
    logic                 value_valid_reg, value_valid_next;
    logic [VALUE_W-1:0]   value_reg,       value_next;
    logic                 ovf_out_reg;

    // working signals
    phase_t               phase_base;
    logic [VALUE_W-1:0]   mag_base;
    logic                 neg_base;
    logic                 ovf_base;
    logic                 is_digit;
    logic                 is_white;
    logic [DIGIT_W-1:0]   digit;
    logic [WIDE_W-1:0]    mag_wide;
    logic [WIDE_W-1:0]    mag_times10;
    logic                 in_fire;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign value_valid = value_valid_reg;
    assign value       = value_reg;
    assign overflow    = ovf_out_reg;

    always_comb
    begin
        // restart wipes state before the byte is consumed
        phase_base = restart ? PH_BEFORE_SIGN : phase_reg;
        mag_base   = restart ? '0 : mag_reg;
        neg_base   = restart ? 1'b0 : neg_reg;
        ovf_base   = restart ? 1'b0 : ovf_reg;

        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        is_white = ((ch >= CHAR_TAB) && (ch <= CHAR_CR)) || (ch == CHAR_SPACE);
        digit    = DIGIT_W'(ch - CHAR_ZERO);

        // exact magnitude * 10 + digit
        mag_wide    = {{(WIDE_W-VALUE_W){1'b0}}, mag_base};
        mag_times10 = (mag_wide << 3) + (mag_wide << 1)
                    + {{(WIDE_W-DIGIT_W){1'b0}}, digit};

        phase_next    = phase_base;
        mag_next      = mag_base;
        neg_next      = neg_base;
        ovf_next      = ovf_base;
        accepted_next = 1'b0;

        unique case (phase_base)
            PH_AFTER_DIGITS:
            begin
                accepted_next = is_white;
            end
            PH_BEFORE_SIGN, PH_BEFORE_DIGITS:
            begin
                priority if ((phase_base == PH_BEFORE_SIGN) && (ch == CHAR_PLUS))
                begin
                    phase_next    = PH_BEFORE_DIGITS;
                    accepted_next = 1'b1;
                end
                else if ((phase_base == PH_BEFORE_SIGN) && (ch == CHAR_MINUS))
                begin
                    neg_next      = 1'b1;
                    phase_next    = PH_BEFORE_DIGITS;
                    accepted_next = 1'b1;
                end
                else if (is_white)
                begin
                    accepted_next = 1'b1;
                end
                else if (is_digit)
                begin
                    mag_next      = mag_times10[VALUE_W-1:0];
                    ovf_next      = ovf_base | (mag_times10 > MAG_LIMIT);
                    phase_next    = PH_DIGITS;
                    accepted_next = 1'b1;
                end
                else
                begin
                    accepted_next = 1'b0;
                end
            end
            PH_DIGITS:
            begin
                priority if (is_digit)
                begin
                    mag_next      = mag_times10[VALUE_W-1:0];
                    ovf_next      = ovf_base | (mag_times10 > MAG_LIMIT);
                    accepted_next = 1'b1;
                end
                else if (is_white)
                begin
                    phase_next    = PH_AFTER_DIGITS;
                    accepted_next = 1'b1;
                end
                else
                begin
                    accepted_next = 1'b0;
                end
            end
            default:
            begin
                accepted_next = 1'b0;
            end
        endcase

        value_valid_next = (phase_next == PH_DIGITS) || (phase_next == PH_AFTER_DIGITS);
        if (!value_valid_next)
            value_next = '0;
        else if (neg_next)
            value_next = '0 - mag_next;
        else
            value_next = mag_next;
    end

    // parser state, updated on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BEFORE_SIGN;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accepted_reg    <= accepted_next;
            value_valid_reg <= value_valid_next;
            value_reg       <= value_next;
            ovf_out_reg     <= ovf_next;
        end
    end

    // no digit yet means a zero value
    `ASSERT_SAME(a_value_zero, clk, rst_n, out_valid && !value_valid, value == '0,
        "value nonzero without a digit")
    // overflow stays set until a restart
    `ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_reg && !(in_fire && restart), ovf_reg,
        "overflow flag cleared without restart")
    // a rejected byte leaves the state alone
    `ASSERT_NEXT(a_reject_hold, clk, rst_n, in_fire && !restart && !accepted_next,
        $stable(mag_reg) && $stable(phase_reg) && $stable(neg_reg),
        "rejected byte changed parser state")
    // every accepted request produces a result next cycle
    `ASSERT_NEXT(a_result_out, clk, rst_n, in_fire, out_valid,
        "accepted request gave no result")

endmodule

// ===== test/tb_decimal_integer_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_integer_stream_parser
// Self-checking bench for the streaming decimal integer parser.
// ----------------------------------------------------------------------------
// A queue of byte requests is filled up front: a short directed run (sign
// handling, whitespace on both sides of the sign, rejected bytes, restart,
// overflow at the 2^31 boundary and past 2^32), then random numbers with
// noise mixed in. A clocked driver feeds the queue through the in_valid /
// in_stall handshake and runs a bit-level model of the parser on every
// accepted request. A clocked monitor pulls results under random out_stall
// and compares each field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_decimal_integer_stream_parser;

    import dis_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 850;
    // no idling on either side once this few requests are left
    localparam int TAIL_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_CYC  = 200000;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              restart;
    } char_req_t;

    typedef struct {
        logic               accepted;
        logic               value_valid;
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } parse_result_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [CHAR_W-1:0]         ch          = '0;
    logic                      restart     = 1'b0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic                      accepted;
    logic                      value_valid;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;

    char_req_t     pending_chars[$];
    parse_result_t expected_parses[$];

    int unsigned total_chars = 0;
    int unsigned sent_chars  = 0;
    int unsigned fail_count  = 0;
    bit          clear_next  = 1'b0;

    // parser model state
    phase_t             mdl_phase = PH_BEFORE_SIGN;
    logic [VALUE_W-1:0] mdl_mag   = '0;
    logic               mdl_neg   = 1'b0;
    logic               mdl_ovf   = 1'b0;

    // handshake idling state, per side
    int unsigned tx_idle_left  = 0;
    int unsigned tx_quiet_left = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_quiet_left = 0;

    string limit_numbers[6] = '{"2147483647", "2147483648", "2147483649",
                                "4294967295", "4294967296", "0000000000042"};

    decimal_integer_stream_parser u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .value_valid (value_valid),
        .value       (value),
        .overflow    (overflow)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model: takes one byte, updates the model state, returns the
    // result the block must show for it. A rejected byte changes nothing.
    // ------------------------------------------------------------------
    function automatic parse_result_t parse_char(input logic [CHAR_W-1:0] c,
                                                 input logic clear);
        parse_result_t      r;
        logic               white;
        logic               digit;
        logic               took;
        logic [CHAR_W-1:0]  digit_val;
        logic [WIDE_W-1:0]  wide;

        if (clear)
        begin
            mdl_phase = PH_BEFORE_SIGN;
            mdl_mag   = '0;
            mdl_neg   = 1'b0;
            mdl_ovf   = 1'b0;
        end

        white     = (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
        digit     = c >= CHAR_ZERO && c <= CHAR_NINE;
        digit_val = c - CHAR_ZERO;
        took      = 1'b0;

        if (mdl_phase == PH_AFTER_DIGITS)
        begin
            // only trailing whitespace from here on
            took = white;
        end
        else if (mdl_phase == PH_BEFORE_SIGN && (c == CHAR_PLUS || c == CHAR_MINUS))
        begin
            took      = 1'b1;
            mdl_neg   = (c == CHAR_MINUS);
            mdl_phase = PH_BEFORE_DIGITS;
        end
        else if (mdl_phase != PH_DIGITS && white)
        begin
            // leading whitespace, also allowed between sign and digits
            took = 1'b1;
        end
        else if (digit)
        begin
            wide = {{(WIDE_W-VALUE_W){1'b0}}, mdl_mag} * 10
                 + {{(WIDE_W-CHAR_W){1'b0}}, digit_val};
            if (wide > MAG_LIMIT)
                mdl_ovf = 1'b1;
            mdl_mag   = wide[VALUE_W-1:0];
            mdl_phase = PH_DIGITS;
            took      = 1'b1;
        end
        else if (white)
        begin
            mdl_phase = PH_AFTER_DIGITS;
            took      = 1'b1;
        end

        r.accepted    = took;
        r.value_valid = (mdl_phase == PH_DIGITS || mdl_phase == PH_AFTER_DIGITS);
        r.value       = !r.value_valid ? '0 : (mdl_neg ? -mdl_mag : mdl_mag);
        r.overflow    = mdl_ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [CHAR_W-1:0] c, input logic r);
        char_req_t req;
        req.ch      = c;
        req.restart = r | clear_next;
        clear_next  = 1'b0;
        pending_chars.push_back(req);
    endtask

    task automatic push_text(input string s, input bit clear_first);
        clear_next = clear_first;
        foreach (s[i])
            push_char(s[i], 1'b0);
    endtask

    function automatic logic [CHAR_W-1:0] any_white();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CHAR_SPACE : CHAR_TAB + k[CHAR_W-1:0];
    endfunction

    // One number token: optional leading blanks, sign, blank after sign,
    // digits, trailing blanks, and now and then a stray byte. Most tokens
    // start with restart so they parse from a clean state.
    task automatic push_random_number();
        int unsigned n;
        int unsigned sel;

        clear_next = ($urandom_range(0, 9) != 0);

        if ($urandom_range(0, 14) == 0)
        begin
            // pure noise, any byte, any restart
            n = $urandom_range(1, 6);
            repeat (n)
                push_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end

        n = $urandom_range(0, 2);
        repeat (n)
            push_char(any_white(), 1'b0);

        sel = $urandom_range(0, 3);
        if (sel < 2)
        begin
            push_char(sel == 0 ? CHAR_PLUS : CHAR_MINUS, 1'b0);
            if ($urandom_range(0, 3) == 0)
                push_char(any_white(), 1'b0);
            // second sign is rejected
            if ($urandom_range(0, 9) == 0)
                push_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS, 1'b0);
        end

        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            push_text(limit_numbers[$urandom_range(0, 5)], clear_next);
        end
        else
        begin
            n = (sel == 1) ? $urandom_range(10, 14) : $urandom_range(1, 6);
            repeat (n)
            begin
                push_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0);
                if ($urandom_range(0, 19) == 0)
                    push_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
            end
        end

        n = $urandom_range(0, 2);
        repeat (n)
            push_char(any_white(), 1'b0);

        // stray digit or sign after the number; the sign is rejected, a digit only after trailing blanks
        if ($urandom_range(0, 7) == 0)
            push_char($urandom_range(0, 1) ? CHAR_ZERO + CHAR_W'($urandom_range(0, 9))
                                           : CHAR_MINUS,
                      1'b0);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next request, holds it while stalled, and runs
    // the model at the edge that accepts it. Idle bursts alternate with
    // quiet stretches; none in the tail of the run.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_req_t req;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_parses.push_back(parse_char(ch, restart));
                sent_chars++;
            end

            if (!(in_valid && in_stall))
            begin
                if (tx_idle_left != 0)
                begin
                    tx_idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() > TAIL_ITEMS && tx_quiet_left == 0
                         && $urandom_range(0, 7) == 0)
                begin
                    tx_idle_left  = $urandom_range(1, 18) - 1;
                    tx_quiet_left = $urandom_range(0, 40);
                    in_valid <= 1'b0;
                end
                else
                begin
                    if (tx_quiet_left != 0)
                        tx_quiet_left--;
                    req = pending_chars.pop_front();
                    in_valid <= 1'b1;
                    ch       <= req.ch;
                    restart  <= req.restart;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted result against the oldest prediction
    // and drives out_stall in bursts, same scheme as the driver.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_parses.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_parses.pop_front();
                    if (accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                        fail_count++;
                    end
                    if (value_valid !== want.value_valid)
                    begin
                        $error("value_valid: expected %0d, actual %0d",
                               want.value_valid, value_valid);
                        fail_count++;
                    end
                    if (value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), value);
                        fail_count++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
                        fail_count++;
                    end
                end
            end

            if (rx_stall_left != 0)
            begin
                rx_stall_left--;
                out_stall <= 1'b1;
            end
            else if (pending_chars.size() > TAIL_ITEMS && rx_quiet_left == 0
                     && $urandom_range(0, 7) == 0)
            begin
                rx_stall_left = $urandom_range(1, 18) - 1;
                rx_quiet_left = $urandom_range(0, 40);
                out_stall <= 1'b1;
            end
            else
            begin
                if (rx_quiet_left != 0)
                    rx_quiet_left--;
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the request queue, release reset, wait for the
    // queue to drain and every prediction to be matched.
    // ------------------------------------------------------------------
    initial
    begin
        // restart on a blank, tab, minus, blank between sign and digit: "- 5"
        push_char(CHAR_SPACE, 1'b1);
        push_char(CHAR_TAB, 1'b0);
        push_char(CHAR_MINUS, 1'b0);
        push_char(CHAR_SPACE, 1'b0);
        push_char(CHAR_NINE - CHAR_W'(4), 1'b0);
        // sign after digits rejected, CR ends the number, digit after it rejected
        push_char(CHAR_PLUS, 1'b0);
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_ZERO + CHAR_W'(7), 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b0);
        // plus then minus: second sign rejected
        push_char(CHAR_PLUS, 1'b1);
        push_char(CHAR_MINUS, 1'b0);
        // exactly 2^31 with a minus still flags overflow, then wrap further
        push_text("-2147483648", 1'b1);
        push_char(CHAR_NINE, 1'b0);
        // restart carried by a byte that is itself rejected
        push_char(8'h80, 1'b1);
        push_char(CHAR_ZERO, 1'b0);

        while (pending_chars.size() < 25 + RANDOM_ITEMS)
            push_random_number();
        total_chars = pending_chars.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_chars != total_chars)
            @(negedge clk);
        while (expected_parses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(2 * CLK_HALF * TIMEOUT_CYC);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/dis_pkg.sv
src/decimal_integer_stream_parser.sv
test/tb_decimal_integer_stream_parser.sv
